// ----- design/prtb_pkg.sv -----
// shared types and constants for the profiling region timer bank
// used by prtb_ctrl, prtb_datapath and the top level; no dependencies
package prtb_pkg;

    localparam int SLOTS      = 32;
    localparam int SLOT_W     = 5;
    localparam int EXT_W      = 9;
    localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TICK_W     = 32;
    localparam int OP_W       = 4;
    localparam int SKIP_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 72;

    // operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_START        = 4'd0;
    localparam logic [OP_W-1:0] OP_END          = 4'd1;
    localparam logic [OP_W-1:0] OP_PAUSE        = 4'd2;
    localparam logic [OP_W-1:0] OP_RESUME       = 4'd3;
    localparam logic [OP_W-1:0] OP_PAUSE_RESUME = 4'd4;
    localparam logic [OP_W-1:0] OP_START_PAUSE  = 4'd5;
    localparam logic [OP_W-1:0] OP_END_RESUME   = 4'd6;
    localparam logic [OP_W-1:0] OP_READ         = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR        = 4'd8;

    localparam logic [STATUS_W-1:0] STATUS_RUNNING  = 2'b10;
    localparam logic [STATUS_W-1:0] STATUS_NO_PAUSE = 2'b01;

    typedef enum logic [1:0] {
        UOP_START,
        UOP_END,
        UOP_PAUSE,
        UOP_RESUME
    } uop_t;

    typedef struct packed {
        logic [TICK_W-1:0] run_count;
        logic [TICK_W-1:0] elapsed_sum;
        logic [TICK_W-1:0] pause_time;
        logic [TICK_W-1:0] start_time;
    } slot_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic rd_en;
        logic rd_b;
        logic ex_en;
        uop_t uop;
        logic report;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

// ----- design/prtb_ctrl.sv -----
// sequencer for the timer bank: splits each word into slot read/update steps
// depends on prtb_pkg
module prtb_ctrl import prtb_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic [OP_W-1:0]   s_op,
    input  logic [SKIP_W-1:0] s_skip,
    output logic              s_tready,
    input  dp_stat_t          stat,
    output ctrl_cmd_t         cmd
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_CLR  = 8'b0000_0010,
        S_RD1  = 8'b0000_0100,
        S_EX1  = 8'b0000_1000,
        S_RD2  = 8'b0001_0000,
        S_EX2  = 8'b0010_0000,
        S_RDO  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic s1_b_reg, s2_en_reg, s2_b_reg, s2_report_reg;
    uop_t s1_uop_reg, s2_uop_reg;

    logic s1_en_next, s1_b_next, s2_en_next, s2_b_next, s2_report_next, clear_next;
    uop_t s1_uop_next, s2_uop_next;

    // step plan for the incoming word
    always_comb begin
        s1_en_next     = 1'b0;
        s1_b_next      = 1'b0;
        s1_uop_next    = UOP_START;
        s2_en_next     = 1'b0;
        s2_b_next      = 1'b0;
        s2_uop_next    = UOP_PAUSE;
        s2_report_next = 1'b0;
        clear_next     = 1'b0;
        unique case (s_op)
            OP_START: begin
                s1_en_next  = 1'b1;
                s1_uop_next = UOP_START;
            end
            OP_END: begin
                s1_en_next  = (s_skip == '0);
                s1_uop_next = UOP_END;
            end
            OP_PAUSE: begin
                s1_en_next  = 1'b1;
                s1_uop_next = UOP_PAUSE;
            end
            OP_RESUME: begin
                s1_en_next  = (s_skip == '0);
                s1_uop_next = UOP_RESUME;
            end
            OP_PAUSE_RESUME: begin
                // resume b first, then a quiet pause of a
                s1_en_next  = 1'b1;
                s1_b_next   = 1'b1;
                s1_uop_next = UOP_RESUME;
                s2_en_next  = 1'b1;
                s2_uop_next = UOP_PAUSE;
            end
            OP_START_PAUSE: begin
                s1_en_next     = 1'b1;
                s1_uop_next    = UOP_START;
                s2_en_next     = 1'b1;
                s2_b_next      = 1'b1;
                s2_uop_next    = UOP_PAUSE;
                s2_report_next = 1'b1;
            end
            OP_END_RESUME: begin
                s1_en_next  = !s_skip[1];
                s1_uop_next = UOP_END;
                s2_en_next  = !s_skip[0];
                s2_b_next   = 1'b1;
                s2_uop_next = UOP_RESUME;
            end
            OP_CLEAR: begin
                clear_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            s1_b_reg      <= s1_b_next;
            s1_uop_reg    <= s1_uop_next;
            s2_en_reg     <= s2_en_next;
            s2_b_reg      <= s2_b_next;
            s2_uop_reg    <= s2_uop_next;
            s2_report_reg <= s2_report_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    priority if (clear_next) state_next = S_CLR;
                    else if (s1_en_next)     state_next = S_RD1;
                    else if (s2_en_next)     state_next = S_RD2;
                    else                     state_next = S_RDO;
                end
            end
            S_CLR: state_next = S_RDO;
            S_RD1: state_next = S_EX1;
            S_EX1: state_next = s2_en_reg ? S_RD2 : S_RDO;
            S_RD2: state_next = S_EX2;
            S_EX2: state_next = S_RDO;
            S_RDO: state_next = S_OUT;
            S_OUT: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd.load     = (state_reg == S_IDLE) && s_tvalid;
        cmd.clear    = (state_reg == S_CLR);
        cmd.rd_en    = (state_reg == S_RD1) || (state_reg == S_RD2) || (state_reg == S_RDO);
        cmd.rd_b     = ((state_reg == S_RD1) && s1_b_reg) || ((state_reg == S_RD2) && s2_b_reg);
        cmd.ex_en    = (state_reg == S_EX1) || (state_reg == S_EX2);
        cmd.uop      = (state_reg == S_EX1) ? s1_uop_reg : s2_uop_reg;
        cmd.report   = (state_reg == S_EX1) ? 1'b1 : s2_report_reg;
        cmd.out_load = (state_reg == S_OUT) && stat.out_free;
    end

endmodule

// ----- design/prtb_datapath.sv -----
// slot memory, per-slot update arithmetic and the result register
// depends on prtb_pkg; driven by prtb_ctrl commands
module prtb_datapath import prtb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    output dp_stat_t             stat,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    slot_t mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;

    logic [SLOT_W-1:0]   slot_a_reg, slot_b_reg;
    logic [TICK_W-1:0]   now_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [IDX_W-1:0] idx_reg;
    logic             ok_reg;
    logic             rvalid_reg;
    slot_t            rword_reg;

    logic [SLOT_W-1:0] rd_slot;
    logic [EXT_W-1:0]  rd_ext;
    logic [IDX_W-1:0]  rd_idx;
    logic              rd_ok;

    slot_t             cur;
    slot_t             upd;
    logic [STATUS_W-1:0] st_bits;
    logic              started, paused;
    logic [TICK_W-1:0] resumed_start;
    logic [TICK_W-1:0] delta;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [TICK_W-1:0]   m_acc_reg, m_exec_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            slot_a_reg <= s_tdata[4:0];
            slot_b_reg <= s_tdata[9:5];
            now_reg    <= s_tdata[43:12];
        end
    end

    assign rd_slot = cmd.rd_b ? slot_b_reg : slot_a_reg;
    assign rd_ext  = {{(EXT_W-SLOT_W){1'b0}}, rd_slot};
    assign rd_idx  = rd_ext[IDX_W-1:0];
    assign rd_ok   = (rd_ext < EXT_W'(SLOTS));

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            idx_reg    <= rd_idx;
            ok_reg     <= rd_ok;
            rvalid_reg <= valid_reg[rd_idx];
            rword_reg  <= mem[rd_idx];
        end
    end

    // an entry never written since reset or clear reads as zero
    assign cur = (rvalid_reg && ok_reg) ? rword_reg : '0;

    assign started       = (cur.start_time != '0);
    assign paused        = (cur.pause_time != '0);
    assign resumed_start = cur.start_time + now_reg - cur.pause_time + TICK_W'(1);
    // end of a paused slot: now - resumed start collapses to pause - start - 1
    assign delta = paused ? (cur.pause_time - cur.start_time - TICK_W'(1))
                          : (now_reg - cur.start_time);

    always_comb begin
        upd     = cur;
        st_bits = '0;
        unique case (cmd.uop)
            UOP_START: begin
                upd.run_count = cur.run_count + TICK_W'(1);
                priority if (paused) begin
                    upd.start_time = resumed_start;
                    upd.pause_time = '0;
                end else if (!started) begin
                    upd.start_time = now_reg;
                end else begin
                    st_bits = ok_reg ? STATUS_RUNNING : '0;
                end
            end
            UOP_PAUSE: begin
                if (started && !paused && ok_reg) begin
                    upd.pause_time = now_reg;
                end else begin
                    st_bits = STATUS_NO_PAUSE;
                end
            end
            UOP_RESUME: begin
                if (started && paused) begin
                    upd.start_time = resumed_start;
                    upd.pause_time = '0;
                end
            end
            UOP_END: begin
                if (started) begin
                    upd.elapsed_sum = cur.elapsed_sum + delta;
                    upd.start_time  = '0;
                    upd.pause_time  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.ex_en && ok_reg) begin
            mem[idx_reg] <= upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.clear) begin
            valid_reg <= '0;
        end else if (cmd.ex_en && ok_reg) begin
            valid_reg[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            status_reg <= '0;
        end else if (cmd.ex_en && cmd.report) begin
            status_reg <= status_reg | st_bits;
        end
    end

    assign stat.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_status_reg <= status_reg;
            m_acc_reg    <= cur.elapsed_sum;
            m_exec_reg   <= cur.run_count;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-2*TICK_W-STATUS_W){1'b0}},
                       m_exec_reg, m_acc_reg, m_status_reg};

endmodule

// ----- design/profiling_region_timer_bank_unit.sv -----
// Profiling region timer bank: a bank of SLOTS timing slots, each with start
// time, pause time, elapsed sum and entry count, updated by event words.
// One event word enters on the s_ channel (operation in s_tuser, slots, skip
// flags and tick in s_tdata). Each word gives exactly one result word on the
// m_ channel: status, elapsed sum and entry count of slot a after the event.
// A word is handled as a sequence of slot steps over one single-ported slot
// memory. Each step is a registered read followed by an update. A word is
// accepted, then takes a read and an update per touched slot (0, 1 or 2
// slots; clear takes a clear step instead) and a final read of slot a before
// its result is loaded; the next word is taken in the cycle after the result
// is loaded, so a new word is not taken while the last one is in flight.
// Reset (aresetn low, synchronous) marks every slot as never written, so all
// slots read as idle with zero sum and count; clear does the same. No
// clearing pass is needed.
// When the receiver stalls, the result stays in the output register and the
// next word is still accepted; it waits before its own result is loaded.
// Depends on prtb_pkg, prtb_ctrl and prtb_datapath.
module profiling_region_timer_bank_unit import prtb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // slot_a[4:0], slot_b[9:5], skip_flags[11:10], now[43:12], zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    // operation[3:0]
    input  logic [OP_W-1:0]      s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], accumulated[33:2], executions[65:34], zero pad
    output logic [M_TDATA_W-1:0] m_tdata
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    prtb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_skip   (s_tdata[11:10]),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    prtb_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- tb/profiling_region_timer_bank_unit_test.sv -----
// testbench for profiling_region_timer_bank_unit: directed and random event words,
// a slot bank predictor, bursty sender and stalling receiver with a self-checking monitor
// depends on prtb_pkg and the profiling_region_timer_bank_unit rtl
`timescale 1ns / 1ps

module profiling_region_timer_bank_unit_test;
    import prtb_pkg::*;

    localparam int EV_BITS     = 2 * SLOT_W + SKIP_W + TICK_W;
    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int EVENT_TOTAL = 900;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [SLOT_W-1:0] slot_a;
        logic [SLOT_W-1:0] slot_b;
        logic [SKIP_W-1:0] skip;
        logic [TICK_W-1:0] now;
    } timer_event_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [TICK_W-1:0]   accumulated;
        logic [TICK_W-1:0]   executions;
    } timer_report_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    timer_event_t  event_backlog[$];
    timer_report_t report_due[$];
    int            error_count = 0;

    // predicted slot bank
    logic [TICK_W-1:0] slot_start[SLOTS];
    logic [TICK_W-1:0] slot_pause[SLOTS];
    logic [TICK_W-1:0] slot_sum[SLOTS];
    logic [TICK_W-1:0] slot_runs[SLOTS];

    logic [TICK_W-1:0] stim_tick;

    profiling_region_timer_bank_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit slot_in_bank(logic [SLOT_W-1:0] s);
        return int'(s) < SLOTS;
    endfunction

    function automatic void bank_clear();
        for (int i = 0; i < SLOTS; i++) begin
            slot_start[i] = '0;
            slot_pause[i] = '0;
            slot_sum[i]   = '0;
            slot_runs[i]  = '0;
        end
    endfunction

    function automatic void bank_resume(logic [SLOT_W-1:0] s, logic [TICK_W-1:0] t);
        if (slot_in_bank(s) && slot_pause[s] != 0 && slot_start[s] != 0) begin
            slot_start[s] = slot_start[s] + t - slot_pause[s] + 1;
            slot_pause[s] = '0;
        end
    endfunction

    function automatic logic [STATUS_W-1:0] bank_pause(logic [SLOT_W-1:0] s,
                                                        logic [TICK_W-1:0] t);
        if (!slot_in_bank(s))
            return STATUS_NO_PAUSE;
        if (slot_start[s] != 0 && slot_pause[s] == 0) begin
            slot_pause[s] = t;
            return '0;
        end
        return STATUS_NO_PAUSE;
    endfunction

    function automatic logic [STATUS_W-1:0] bank_start(logic [SLOT_W-1:0] s,
                                                        logic [TICK_W-1:0] t);
        if (!slot_in_bank(s))
            return '0;
        slot_runs[s] = slot_runs[s] + 1;
        if (slot_pause[s] != 0) begin
            slot_start[s] = slot_start[s] + t - slot_pause[s] + 1;
            slot_pause[s] = '0;
            return '0;
        end
        if (slot_start[s] == 0) begin
            slot_start[s] = t;
            return '0;
        end
        return STATUS_RUNNING;
    endfunction

    function automatic void bank_end(logic [SLOT_W-1:0] s, logic [TICK_W-1:0] t);
        if (slot_in_bank(s) && slot_start[s] != 0) begin
            if (slot_pause[s] != 0)
                slot_start[s] = slot_start[s] + t - slot_pause[s] + 1;
            slot_sum[s]   = slot_sum[s] + t - slot_start[s];
            slot_start[s] = '0;
            slot_pause[s] = '0;
        end
    endfunction

    function automatic timer_report_t bank_apply(timer_event_t ev);
        timer_report_t r;
        r.status = '0;
        case (ev.op)
            OP_START: r.status = bank_start(ev.slot_a, ev.now);
            OP_END: begin
                if (ev.skip == 0) bank_end(ev.slot_a, ev.now);
            end
            OP_PAUSE: r.status = bank_pause(ev.slot_a, ev.now);
            OP_RESUME: begin
                if (ev.skip == 0) bank_resume(ev.slot_a, ev.now);
            end
            OP_PAUSE_RESUME: begin
                // b is resumed before a is paused, so a == b ends paused if it was started
                bank_resume(ev.slot_b, ev.now);
                void'(bank_pause(ev.slot_a, ev.now));
            end
            OP_START_PAUSE: begin
                r.status = bank_start(ev.slot_a, ev.now);
                r.status = r.status | bank_pause(ev.slot_b, ev.now);
            end
            OP_END_RESUME: begin
                if (!ev.skip[1]) bank_end(ev.slot_a, ev.now);
                if (!ev.skip[0]) bank_resume(ev.slot_b, ev.now);
            end
            OP_CLEAR: bank_clear();
            default: ;  // read and unused codes change nothing
        endcase
        r.accumulated = slot_in_bank(ev.slot_a) ? slot_sum[ev.slot_a] : '0;
        r.executions  = slot_in_bank(ev.slot_a) ? slot_runs[ev.slot_a] : '0;
        return r;
    endfunction

    function automatic void queue_event(logic [OP_W-1:0] op, logic [SLOT_W-1:0] a,
                                        logic [SLOT_W-1:0] b, logic [SKIP_W-1:0] skip,
                                        logic [TICK_W-1:0] now);
        timer_event_t ev;
        ev.op     = op;
        ev.slot_a = a;
        ev.slot_b = b;
        ev.skip   = skip;
        ev.now    = now;
        event_backlog.push_back(ev);
    endfunction

    function automatic logic [TICK_W-1:0] next_tick();
        if ($urandom_range(0, 49) == 0)
            stim_tick = stim_tick + $urandom;
        else
            stim_tick = stim_tick + $urandom_range(1, 900);
        return stim_tick;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot();
        // half the time a few hot slots so runs collide
        if ($urandom_range(0, 1) == 0)
            return SLOT_W'($urandom_range(0, 3));
        return SLOT_W'($urandom_range(0, SLOTS - 1));
    endfunction

    // sender: bursts of random length, random gaps between them
    timer_event_t offered;
    int           burst_left = 0;
    int           gap_left = 0;

    always @(posedge aclk) begin
        logic         fire;
        logic         next_valid;
        timer_event_t ev;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            fire = s_tvalid && s_tready;
            if (fire)
                report_due.push_back(bank_apply(offered));
            if (!s_tvalid || fire) begin
                next_valid = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (event_backlog.size() > 0) begin
                    ev = event_backlog.pop_front();
                    offered = ev;
                    next_valid = 1'b1;
                    s_tdata <= {{(S_TDATA_W - EV_BITS){1'b0}}, ev.now, ev.skip,
                                ev.slot_b, ev.slot_a};
                    s_tuser <= ev.op;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                s_tvalid <= next_valid;
            end
        end
    end

    // receiver: phases of full speed, fixed pattern, light and heavy random stalls, plus two long holds
    localparam logic [10:0] STALL_PATTERN = 11'b10110011101;
    int unsigned rcv_cycle = 0;
    int          taken = 0;
    int          hold_left = 0;
    int          holds_done = 0;

    always @(posedge aclk) begin
        logic rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rcv_cycle++;
            if (m_tvalid && m_tready)
                taken++;
            if ((holds_done == 0 && taken >= 250) || (holds_done == 1 && taken >= 600)) begin
                hold_left = LONG_HOLD;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (rcv_cycle[8:7])
                    2'd0: rdy = 1'b1;
                    2'd1: rdy = STALL_PATTERN[rcv_cycle % 11];
                    2'd2: rdy = ($urandom_range(0, 3) != 0);
                    default: rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_tready <= rdy;
        end
    end

    function automatic void compare_field(string field, logic [TICK_W-1:0] want,
                                          logic [TICK_W-1:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
            error_count++;
        end
    endfunction

    // monitor: every result word against the oldest prediction
    always @(posedge aclk) begin
        timer_report_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (report_due.size() == 0) begin
                $display("%0t ns: unexpected result word, expected none, actual %h",
                         $time, m_tdata);
                error_count++;
            end else begin
                want = report_due.pop_front();
                compare_field("status", TICK_W'(want.status), TICK_W'(m_tdata[1:0]));
                compare_field("accumulated", want.accumulated, m_tdata[33:2]);
                compare_field("executions", want.executions, m_tdata[65:34]);
            end
        end
    end

    // watchdog on cycles without any handshake
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("profiling_region_timer_bank_unit_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [SLOT_W-1:0] sa;
        logic [SLOT_W-1:0] sb;
        int                pick;
        int                reps;

        bank_clear();
        stim_tick = $urandom;

        // directed part
        queue_event(OP_READ, 0, 0, 0, 5);                   // reset state
        queue_event(OP_START, 0, 31, 0, 0);                 // start at tick zero stays idle
        queue_event(OP_START, 0, 0, 0, 100);
        queue_event(OP_START, 0, 0, 0, 120);                // already running
        queue_event(OP_PAUSE, 0, 0, 0, 0);                  // pause at tick zero is lost
        queue_event(OP_PAUSE, 0, 0, 0, 150);
        queue_event(OP_PAUSE, 0, 0, 0, 160);                // already paused
        queue_event(OP_RESUME, 0, 0, 3, 170);               // skipped
        queue_event(OP_RESUME, 0, 0, 0, 200);
        queue_event(OP_END, 0, 0, 1, 210);                  // skipped
        queue_event(OP_END, 0, 0, 0, 300);
        queue_event(OP_PAUSE, 0, 0, 0, 310);                // idle slot cannot pause
        queue_event(OP_START_PAUSE, 31, 31, 3, 32'hFFFF_FFF0);  // same slot both halves
        queue_event(OP_PAUSE_RESUME, 31, 31, 3, 32'hFFFF_FFFF);
        queue_event(OP_END_RESUME, 31, 31, 0, 5);           // end across tick wrap
        queue_event(OP_START, 1, 0, 0, 1000);
        queue_event(OP_START, 2, 0, 0, 1001);
        queue_event(OP_START_PAUSE, 1, 2, 0, 1010);
        queue_event(OP_END_RESUME, 2, 1, 2, 1020);          // end skipped
        queue_event(OP_END_RESUME, 1, 2, 1, 1030);          // resume skipped
        queue_event(OP_PAUSE_RESUME, 2, 2, 0, 1040);
        queue_event(4'd9, 2, 0, 0, 1050);                   // unused codes read
        queue_event(4'd15, 1, 0, 0, 1060);
        queue_event(OP_CLEAR, 2, 0, 0, 1070);
        queue_event(OP_READ, 1, 0, 0, 1080);
        queue_event(OP_END, 2, 0, 0, 1090);

        // random part: mostly well-formed runs, some noise
        while (event_backlog.size() < EVENT_TOTAL) begin
            pick = $urandom_range(0, 9);
            sa = pick_slot();
            sb = pick_slot();
            if (pick < 4) begin
                queue_event(OP_START, sa, SLOT_W'($urandom), 0, next_tick());
                reps = $urandom_range(0, 3);
                for (int i = 0; i < reps; i++) begin
                    queue_event(OP_PAUSE, sa, SLOT_W'($urandom), 0, next_tick());
                    queue_event(OP_RESUME, sa, SLOT_W'($urandom), 0, next_tick());
                end
                queue_event(OP_END, sa, SLOT_W'($urandom), 0, next_tick());
                queue_event(OP_READ, sa, SLOT_W'($urandom), SKIP_W'($urandom), next_tick());
            end else if (pick < 6) begin
                // nested region: outer paused while inner runs
                queue_event(OP_START, sa, sb, 0, next_tick());
                queue_event(OP_START_PAUSE, sb, sa, 0, next_tick());
                queue_event(OP_END_RESUME, sb, sa, 0, next_tick());
                queue_event(OP_END, sa, sb, 0, next_tick());
            end else if (pick < 7) begin
                queue_event(OP_START, sa, sb, 0, next_tick());
                queue_event(OP_START, sb, sa, 0, next_tick());
                queue_event(OP_PAUSE, sb, sa, 0, next_tick());
                queue_event(OP_PAUSE_RESUME, sa, sb, SKIP_W'($urandom), next_tick());
                queue_event(OP_END_RESUME, sb, sa, 0, next_tick());
                queue_event(OP_END, sa, sb, 0, next_tick());
            end else begin
                reps = $urandom_range(1, 3);
                for (int i = 0; i < reps; i++) begin
                    pick = $urandom_range(0, 15);
                    // keep clears rare so the slots build up history
                    if (pick == OP_CLEAR && $urandom_range(0, 9) != 0)
                        pick = OP_READ;
                    queue_event(OP_W'(pick), SLOT_W'($urandom), SLOT_W'($urandom),
                                SKIP_W'($urandom),
                                ($urandom_range(0, 1) == 0) ? TICK_W'($urandom) : next_tick());
                end
            end
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (event_backlog.size() != 0 || s_tvalid || report_due.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (error_count == 0)
            $display("profiling_region_timer_bank_unit_test: done, clean");
        else
            $display("profiling_region_timer_bank_unit_test: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
design/prtb_pkg.sv
design/prtb_ctrl.sv
design/prtb_datapath.sv
design/profiling_region_timer_bank_unit.sv
tb/profiling_region_timer_bank_unit_test.sv
